/* rtl/clab_pkg.sv */
// Package: shared types, widths and constants for the look-at basis pipeline.
`timescale 1ns / 1ps
`default_nettype none
package clab_pkg;
   localparam int unsigned CoordWidth = 32;
   localparam int unsigned DiffWidth  = 33;
   localparam int unsigned MagWidth   = 30;
   localparam int unsigned SqWidth    = 62;
   localparam int unsigned LenWidth   = 31;
   localparam int unsigned QuoWidth   = 31;
   localparam int unsigned DivSteps   = 31;
   localparam int unsigned SqrtSteps  = 31;
   localparam int unsigned OutWidth   = 32;
   localparam logic [OutWidth-1:0] OneQ30 = 32'h4000_0000;

   typedef enum logic {
      STATUS_OK         = 1'b0,
      STATUS_DEGENERATE = 1'b1
   } status_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] cam_x;
      logic signed [CoordWidth-1:0] cam_y;
      logic signed [CoordWidth-1:0] cam_z;
      logic signed [CoordWidth-1:0] aim_x;
      logic signed [CoordWidth-1:0] aim_y;
      logic signed [CoordWidth-1:0] aim_z;
   } req_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] side_x;
      logic signed [OutWidth-1:0] side_y;
      logic signed [OutWidth-1:0] side_z;
      logic signed [OutWidth-1:0] upv_x;
      logic signed [OutWidth-1:0] upv_y;
      logic signed [OutWidth-1:0] upv_z;
      logic signed [OutWidth-1:0] fwd_x;
      logic signed [OutWidth-1:0] fwd_y;
      logic signed [OutWidth-1:0] fwd_z;
      logic                       status;
   } rsp_type;

   // sign/degenerate flags carried along the pipeline
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic neg_z;
      logic degen;
   } flags_type;

   // bit length of a 33-bit magnitude
   function automatic logic [5:0] bit_len(input logic [DiffWidth-1:0] m);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < DiffWidth; i++) begin
         if (m[i]) p = 6'(i + 1);
      end
      return p;
   endfunction

   // shift magnitude so a value of bit length p lands in [2^29, 2^30)
   function automatic logic [MagWidth-1:0] norm_shift(input logic [DiffWidth-1:0] m,
                                                      input logic [5:0] p);
      logic [DiffWidth+MagWidth-1:0] w;
      w = {{MagWidth{1'b0}}, m};
      if (p < 6'd30) w = w << (6'd30 - p);
      else w = w >> (p - 6'd30);
      return w[MagWidth-1:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/clab_if.sv */
// Interfaces: valid/ready channels for requests and responses.
`timescale 1ns / 1ps
`default_nettype none
interface clab_req_if;
   logic               valid;
   logic               ready;
   clab_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface clab_rsp_if;
   logic               valid;
   logic               ready;
   clab_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/clab_sqrt.sv */
// Pipelined integer square root: one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module clab_sqrt #(
   parameter int unsigned Width = 62
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic [Width-1:0]     value,
   output logic [Width/2-1:0]        root
);
   localparam int unsigned Steps = Width / 2;
   logic [Width-1:0]   rem_ff  [Steps+1];
   logic [Width/2-1:0] res_ff  [Steps+1];
   logic [Width-1:0]   rem_in  [Steps];
   logic [Width/2-1:0] res_in  [Steps];

   always_comb begin
      rem_ff[0] = value;
      res_ff[0] = '0;
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      localparam int unsigned Sh = 2 * (Steps - 1 - s);
      logic [Width+1:0] trial;
      logic [Width+1:0] remw;
      always_comb begin
         remw  = {2'b00, rem_ff[s]};
         trial = ({{(Width/2+2){1'b0}}, res_ff[s]} << (Sh + 2))
                 | ((Width+2)'(1) << Sh);
         if (remw >= trial) begin
            rem_in[s] = Width'(remw - trial);
            res_in[s] = {res_ff[s][Width/2-2:0], 1'b1};
         end else begin
            rem_in[s] = rem_ff[s];
            res_in[s] = {res_ff[s][Width/2-2:0], 1'b0};
         end
      end
      logic [Width-1:0]   rem_q;
      logic [Width/2-1:0] res_q;
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_q <= rem_in[s];
            res_q <= res_in[s];
         end
      end
      always_comb begin
         rem_ff[s+1] = rem_q;
         res_ff[s+1] = res_q;
      end
   end

   assign root = res_ff[Steps];
endmodule
`default_nettype wire

/* rtl/clab_div.sv */
// Pipelined restoring divider: round(a * 2^30 / len), one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module clab_div (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [clab_pkg::MagWidth-1:0] num,
   input  wire logic [clab_pkg::LenWidth-1:0] den,
   output logic [clab_pkg::QuoWidth-1:0]      quo
);
   localparam int unsigned Nw = 62;
   localparam int unsigned Steps = clab_pkg::DivSteps;
   // dividend = a*2^30 + den/2; quotient < 2^31
   logic [Nw-1:0] rem_ff [Steps+1];
   logic [clab_pkg::QuoWidth-1:0] q_ff [Steps+1];
   logic [clab_pkg::LenWidth-1:0] d_ff [Steps+1];

   always_comb begin
      rem_ff[0] = {2'b00, num, 30'd0} + Nw'(den >> 1);
      q_ff[0]   = '0;
      d_ff[0]   = den;
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      localparam int unsigned Sh = Steps - 1 - s;
      logic [Nw+Steps-1:0] sub;
      logic [Nw-1:0] r_n;
      logic [clab_pkg::QuoWidth-1:0] q_n;
      logic [Nw-1:0] r_q;
      logic [clab_pkg::QuoWidth-1:0] q_q;
      logic [clab_pkg::LenWidth-1:0] d_q;
      always_comb begin
         sub = {{(Nw+Steps-clab_pkg::LenWidth){1'b0}}, d_ff[s]} << Sh;
         if ({{Steps{1'b0}}, rem_ff[s]} >= sub) begin
            r_n = Nw'({{Steps{1'b0}}, rem_ff[s]} - sub);
            q_n = q_ff[s] | (clab_pkg::QuoWidth'(1) << Sh);
         end else begin
            r_n = rem_ff[s];
            q_n = q_ff[s];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            r_q <= r_n;
            q_q <= q_n;
            d_q <= d_ff[s];
         end
      end
      always_comb begin
         rem_ff[s+1] = r_q;
         q_ff[s+1]   = q_q;
         d_ff[s+1]   = d_q;
      end
   end

   assign quo = q_ff[Steps];
endmodule
`default_nettype wire

/* rtl/camera_look_at_basis_unit.sv */
// Top level: look-at basis pipeline (difference, normalize, sqrt, divide, cross).
// One item per cycle while the result side is not stalled; the depth is set by the bit-per-stage
// square root (31 stages) and divider (31 stages) plus three front and three back stages.
// The whole pipeline advances only when its last stage is empty or being taken,
// so a stall on the result side holds every stage in place.
`timescale 1ns / 1ps
`default_nettype none
module camera_look_at_basis_unit (
   input wire logic    clock,
   input wire logic    reset,
   clab_req_if.sink    req,
   clab_rsp_if.source  rsp
);
   localparam int unsigned Lat = 68;
   localparam int unsigned SqrtLat = 31;
   localparam int unsigned DivLat = 31;
   localparam int unsigned Mw = clab_pkg::MagWidth;

   logic [Lat-1:0] vld_ff;
   logic           adv;
   assign adv = !vld_ff[Lat-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Lat-2:0], req.valid};
   end

   // stage 1: differences
   logic signed [clab_pkg::DiffWidth-1:0] dx_ff, dy_ff, dz_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff <= 33'(signed'(req.data.aim_x)) - 33'(signed'(req.data.cam_x));
         dy_ff <= 33'(signed'(req.data.aim_y)) - 33'(signed'(req.data.cam_y));
         dz_ff <= 33'(signed'(req.data.aim_z)) - 33'(signed'(req.data.cam_z));
      end
   end

   // stage 2: normalize
   logic [32:0] mx, my, mz, mf, mh;
   always_comb begin
      mx = dx_ff[32] ? 33'(-dx_ff) : dx_ff;
      my = dy_ff[32] ? 33'(-dy_ff) : dy_ff;
      mz = dz_ff[32] ? 33'(-dz_ff) : dz_ff;
      mh = (mx > mz) ? mx : mz;
      mf = (mh > my) ? mh : my;
   end
   logic [Mw-1:0] fa_ff [3];
   logic [Mw-1:0] ha_ff [2];
   clab_pkg::flags_type fl_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fa_ff[0] <= clab_pkg::norm_shift(mx, clab_pkg::bit_len(mf));
         fa_ff[1] <= clab_pkg::norm_shift(my, clab_pkg::bit_len(mf));
         fa_ff[2] <= clab_pkg::norm_shift(mz, clab_pkg::bit_len(mf));
         ha_ff[0] <= clab_pkg::norm_shift(mx, clab_pkg::bit_len(mh));
         ha_ff[1] <= clab_pkg::norm_shift(mz, clab_pkg::bit_len(mh));
         fl_ff <= '{neg_x: dx_ff[32], neg_y: dy_ff[32], neg_z: dz_ff[32],
                    degen: (mh == 33'd0)};
      end
   end

   // stage 3: squares summed
   logic [61:0] fs_ff, hs_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fs_ff <= 62'(fa_ff[0]) * 62'(fa_ff[0]) + 62'(fa_ff[1]) * 62'(fa_ff[1])
                  + 62'(fa_ff[2]) * 62'(fa_ff[2]);
         hs_ff <= 62'(ha_ff[0]) * 62'(ha_ff[0]) + 62'(ha_ff[1]) * 62'(ha_ff[1]);
      end
   end
   logic [Mw-1:0] fa2_ff [3];
   logic [Mw-1:0] ha2_ff [2];
   clab_pkg::flags_type fl2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fa2_ff <= fa_ff;
         ha2_ff <= ha_ff;
         fl2_ff <= fl_ff;
      end
   end

   logic [30:0] flen, hlen;
   clab_sqrt #(.Width(62)) u_fsqrt (.clock, .enable(adv), .value(fs_ff),
      .root(flen));
   clab_sqrt #(.Width(62)) u_hsqrt (.clock, .enable(adv), .value(hs_ff),
      .root(hlen));

   // delay magnitudes and flags alongside the square root
   logic [Mw-1:0] fd_ff [SqrtLat][3];
   logic [Mw-1:0] hd_ff [SqrtLat][2];
   clab_pkg::flags_type fld_ff [SqrtLat];
   always_ff @(posedge clock) begin
      if (adv) begin
         fd_ff[0] <= fa2_ff;
         hd_ff[0] <= ha2_ff;
         fld_ff[0] <= fl2_ff;
         for (int i = 1; i < SqrtLat; i++) begin
            fd_ff[i] <= fd_ff[i-1];
            hd_ff[i] <= hd_ff[i-1];
            fld_ff[i] <= fld_ff[i-1];
         end
      end
   end

   logic [30:0] q [5];
   clab_div u_d0 (.clock, .enable(adv), .num(fd_ff[SqrtLat-1][0]), .den(flen), .quo(q[0]));
   clab_div u_d1 (.clock, .enable(adv), .num(fd_ff[SqrtLat-1][1]), .den(flen), .quo(q[1]));
   clab_div u_d2 (.clock, .enable(adv), .num(fd_ff[SqrtLat-1][2]), .den(flen), .quo(q[2]));
   clab_div u_d3 (.clock, .enable(adv), .num(hd_ff[SqrtLat-1][1]), .den(hlen), .quo(q[3]));
   clab_div u_d4 (.clock, .enable(adv), .num(hd_ff[SqrtLat-1][0]), .den(hlen), .quo(q[4]));

   clab_pkg::flags_type fle_ff [DivLat];
   always_ff @(posedge clock) begin
      if (adv) begin
         fle_ff[0] <= fld_ff[SqrtLat-1];
         for (int i = 1; i < DivLat; i++) fle_ff[i] <= fle_ff[i-1];
      end
   end

   // signed components
   logic signed [31:0] fx_ff, fy_ff, fz_ff, rx_ff, rz_ff;
   clab_pkg::flags_type flo_ff;
   clab_pkg::flags_type fe;
   assign fe = fle_ff[DivLat-1];
   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff <= fe.neg_x ? -32'(q[0]) : 32'(q[0]);
         fy_ff <= fe.neg_y ? -32'(q[1]) : 32'(q[1]);
         fz_ff <= fe.neg_z ? -32'(q[2]) : 32'(q[2]);
         rx_ff <= fe.neg_z ? -32'(q[3]) : 32'(q[3]);
         rz_ff <= fe.neg_x ? 32'(q[4]) : -32'(q[4]);
         flo_ff <= fe;
      end
   end

   // products
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [31:0] fx2_ff, fy2_ff, fz2_ff, rx2_ff, rz2_ff;
   clab_pkg::flags_type flp_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= fy_ff * rz_ff;
         p1_ff <= fz_ff * rx_ff;
         p2_ff <= fx_ff * rz_ff;
         p3_ff <= fy_ff * rx_ff;
         fx2_ff <= fx_ff; fy2_ff <= fy_ff; fz2_ff <= fz_ff;
         rx2_ff <= rx_ff; rz2_ff <= rz_ff;
         flp_ff <= flo_ff;
      end
   end

   function automatic logic [31:0] rnd(input logic signed [64:0] v);
      logic [64:0] m;
      logic [64:0] r;
      m = v[64] ? 65'(-v) : v;
      r = (m + 65'(64'd1 << 29)) >> 30;
      if (r > 65'(clab_pkg::OneQ30)) r = 65'(clab_pkg::OneQ30);
      return v[64] ? 32'(-r) : r[31:0];
   endfunction

   clab_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         if (flp_ff.degen) begin
            out_ff.side_x <= '0;
            out_ff.side_y <= '0;
            out_ff.side_z <= '0;
            out_ff.upv_x <= '0;
            out_ff.upv_y <= '0;
            out_ff.upv_z <= '0;
            out_ff.fwd_x <= '0;
            out_ff.fwd_y <= '0;
            out_ff.fwd_z <= '0;
            out_ff.status <= clab_pkg::STATUS_DEGENERATE;
         end else begin
            out_ff.side_x <= rx2_ff;
            out_ff.side_y <= '0;
            out_ff.side_z <= rz2_ff;
            out_ff.upv_x <= rnd(65'(p0_ff));
            out_ff.upv_y <= rnd(65'(p1_ff) - 65'(p2_ff));
            out_ff.upv_z <= rnd(-65'(p3_ff));
            out_ff.fwd_x <= fx2_ff;
            out_ff.fwd_y <= fy2_ff;
            out_ff.fwd_z <= fz2_ff;
            out_ff.status <= clab_pkg::STATUS_OK;
         end
      end
   end

   assign rsp.valid = vld_ff[Lat-1];
   assign rsp.data  = out_ff;
endmodule
`default_nettype wire

/* rtl/clab_checker.sv */
// Checker: port-level properties of the look-at basis unit, and its bind.
`timescale 1ns / 1ps
`default_nettype none
module clab_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              req_ready,
   input wire clab_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("not ready while output empty");
   a_sidey: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.side_y == '0) else $error("side_y nonzero");
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.fwd_x == '0 && rsp_data.side_z == '0)
      else $error("degenerate result not zero");
endmodule

bind camera_look_at_basis_unit clab_checker u_clab_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .req_ready(req.ready), .rsp_data(rsp.data));
`default_nettype wire
